@@ hdl/flch_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package flch_pkg;

    // field widths fixed by the frame descriptor and result layout
    localparam int LINK_W    = 16;
    localparam int LEN_W     = 16;
    localparam int CNT32_W   = 32;
    localparam int KEY_W     = LINK_W + LEN_W;
    localparam int KIND_W    = 3;
    localparam int OUTCOME_W = 2;
    localparam int SLOT_W    = 5;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_REGS  = 4;
    localparam int KINDS     = 5;

    // frame kinds
    localparam logic [KIND_W-1:0] KIND_PROFILE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ENDSYS   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SRC_CNT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DST_CNT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 3'd4;

    // bucket outcomes
    localparam logic [OUTCOME_W-1:0] OUT_CLASSIFIED = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_HIT        = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_NEW        = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_FULL       = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROFILE_LEN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENDSYS_LEN  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_CNT_LEN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_CNT_LEN = 8'd3;

    localparam logic [LEN_W-1:0] PROFILE_LEN_RST = 16'd137;
    localparam logic [LEN_W-1:0] ENDSYS_LEN_RST  = 16'd353;
    localparam logic [LEN_W-1:0] SRC_CNT_LEN_RST = 16'd961;
    localparam logic [LEN_W-1:0] DST_CNT_LEN_RST = 16'd385;

    localparam logic [1:0] CLS_LAST = 2'(CFG_REGS - 1);

    localparam logic [CNT32_W-1:0] CNT_ONE = 32'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_SCAN,
        S_BUCKET,
        S_KIND
    } t_state;

endpackage

`default_nettype wire

@@ hdl/flch_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shared datapath unit: one key/length equality compare and one
// saturating 32-bit increment, reused by every step of the sequencer.
module flch_alu
    import flch_pkg::*;
(
    input  wire logic [KEY_W-1:0]   i_cmp_a,
    input  wire logic [KEY_W-1:0]   i_cmp_b,
    input  wire logic [CNT32_W-1:0] i_inc_a,
    output logic                    o_eq,
    output logic [CNT32_W-1:0]      o_inc
);

    assign o_eq  = (i_cmp_a == i_cmp_b);
    assign o_inc = (&i_inc_a) ? i_inc_a : i_inc_a + CNT_ONE;

endmodule

`default_nettype wire

@@ hdl/flch_bucket_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bucket table: one write port, one registered read port.
module flch_bucket_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hdl/frame_length_classifier_histogram.sv @@
// Frame length classifier with an unknown-length histogram.
// Input stream (s_axis): one transaction per received frame, tdata holds
// link id and total length, tuser the payload-present flag. Each frame is
// counted, matched by exact length against four configured lengths, and
// otherwise looked up in a table of BUCKETS (link id, length) entries.
// Output stream (m_axis): one result transaction per frame with the kind in
// tuser and all updated counters, bucket outcome, slot and hit count in tdata.
// Config channel: write index/data with valid/ready, always ready; write only
// while the block is idle. Indexes 4 and up are ignored.
// Sequence: one frame at a time. Accept, then length compares, one per
// register until a match (skipped if no payload or short); unmatched frames
// get a table scan, one entry per cycle through the single read port of the
// bucket RAM and the shared comparator, ending at a hit or after all used
// entries, then a bucket update; last comes the result step.
// The result sits in an output register; a new frame is accepted while it
// waits, but the next result holds in the sequencer until it is taken.
// Reset: counters, table fill count and length registers return to their
// reset values; table contents are not cleared, no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module frame_length_classifier_histogram
    import flch_pkg::*;
#(
    parameter int BUCKETS       = 32,
    parameter int TRAILER_BYTES = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // tdata: link_id[15:0], frame_len[31:16]
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [31:0]          i_s_axis_tdata,
    // tuser: payload_present[0]
    input  wire logic [0:0]           i_s_axis_tuser,
    // tdata: kind_total[31:0], all_frames_total[63:32], bucket_outcome[65:64],
    //        bucket_slot[70:66], bucket_hits[102:71], lost_pairs_total[134:103]
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [135:0]              o_m_axis_tdata,
    // tuser: frame_kind[2:0]
    output logic [KIND_W-1:0]         o_m_axis_tuser,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LEN_W-1:0]     i_cfg_data
);

    localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CNT_W = $clog2(BUCKETS + 1);
    localparam int ROW_W = KEY_W + CNT32_W;

    t_state r_state, n_state;

    logic [LINK_W-1:0]    r_link, n_link;
    logic [LEN_W-1:0]     r_len, n_len;
    logic                 r_present, n_present;
    logic [LEN_W-1:0]     r_cfg [CFG_REGS];
    logic [1:0]           r_cls_idx, n_cls_idx;
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic [CNT32_W-1:0]   r_frame_cnt, n_frame_cnt;
    logic [CNT32_W-1:0]   r_kind_cnt [KINDS];
    logic [CNT32_W-1:0]   n_kind_cnt [KINDS];
    logic [CNT32_W-1:0]   r_lost_cnt, n_lost_cnt;
    logic [CNT_W-1:0]     r_used, n_used;
    logic [CNT_W-1:0]     r_rd_idx, n_rd_idx;
    logic                 r_cmp_pend, n_cmp_pend;
    logic [IDX_W-1:0]     r_cmp_idx, n_cmp_idx;
    logic [OUTCOME_W-1:0] r_outcome, n_outcome;
    logic [IDX_W-1:0]     r_slot, n_slot;
    logic [CNT32_W-1:0]   r_hits, n_hits;
    logic                 r_out_valid, n_out_valid;

    logic [KIND_W-1:0]    r_o_kind;
    logic [CNT32_W-1:0]   r_o_kind_total;
    logic [CNT32_W-1:0]   r_o_all;
    logic [OUTCOME_W-1:0] r_o_outcome;
    logic [SLOT_W-1:0]    r_o_slot;
    logic [CNT32_W-1:0]   r_o_hits;
    logic [CNT32_W-1:0]   r_o_lost;

    logic                 s_accept;
    logic                 out_load;
    logic                 len_ok;
    logic [KEY_W-1:0]     key;
    logic [KEY_W-1:0]     cmp_a, cmp_b;
    logic [CNT32_W-1:0]   inc_a, inc_out;
    logic                 cmp_eq;
    logic                 wr_en, rd_en;
    logic [ROW_W-1:0]     wr_data, rd_data;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign len_ok   = (r_len >= LEN_W'(TRAILER_BYTES));
    assign key      = {r_link, r_len};
    assign slot_ext = {{SLOT_W{1'b0}}, r_slot};

    flch_alu u_alu (
        .i_cmp_a (cmp_a),
        .i_cmp_b (cmp_b),
        .i_inc_a (inc_a),
        .o_eq    (cmp_eq),
        .o_inc   (inc_out)
    );

    flch_bucket_ram #(
        .DEPTH (BUCKETS),
        .AW    (IDX_W),
        .DW    (ROW_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // operand selection for the shared unit
    always_comb begin
        if (r_state == S_CLASS) begin
            cmp_a = {{LINK_W{1'b0}}, r_len};
            cmp_b = {{LINK_W{1'b0}}, r_cfg[r_cls_idx]};
        end else begin
            cmp_a = key;
            cmp_b = rd_data[ROW_W-1:CNT32_W];
        end
        unique case (r_state)
            S_BUCKET: inc_a = (r_outcome == OUT_HIT) ? rd_data[CNT32_W-1:0] : r_lost_cnt;
            S_KIND:   inc_a = r_kind_cnt[r_kind];
            default:  inc_a = r_frame_cnt;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_link      = r_link;
        n_len       = r_len;
        n_present   = r_present;
        n_cls_idx   = r_cls_idx;
        n_kind      = r_kind;
        n_frame_cnt = r_frame_cnt;
        n_kind_cnt  = r_kind_cnt;
        n_lost_cnt  = r_lost_cnt;
        n_used      = r_used;
        n_rd_idx    = r_rd_idx;
        n_cmp_pend  = r_cmp_pend;
        n_cmp_idx   = r_cmp_idx;
        n_outcome   = r_outcome;
        n_slot      = r_slot;
        n_hits      = r_hits;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_data     = {key, CNT_ONE};
        out_load    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_link      = i_s_axis_tdata[15:0];
                    n_len       = i_s_axis_tdata[31:16];
                    n_present   = i_s_axis_tuser[0];
                    n_frame_cnt = inc_out;
                    n_cls_idx   = '0;
                    n_state     = S_CLASS;
                end
            end
            S_CLASS: begin
                priority if (!(r_present && len_ok)) begin
                    n_kind     = KIND_UNKNOWN;
                    n_rd_idx   = '0;
                    n_cmp_pend = 1'b0;
                    n_state    = S_SCAN;
                end else if (cmp_eq) begin
                    n_kind    = {1'b0, r_cls_idx};
                    n_outcome = OUT_CLASSIFIED;
                    n_slot    = '0;
                    n_hits    = '0;
                    n_state   = S_KIND;
                end else if (r_cls_idx == CLS_LAST) begin
                    n_kind     = KIND_UNKNOWN;
                    n_rd_idx   = '0;
                    n_cmp_pend = 1'b0;
                    n_state    = S_SCAN;
                end else begin
                    n_cls_idx = r_cls_idx + 2'd1;
                end
            end
            S_SCAN: begin
                // reads are issued one entry ahead of the compare
                priority if (r_cmp_pend && cmp_eq) begin
                    n_outcome  = OUT_HIT;
                    n_slot     = r_cmp_idx;
                    n_cmp_pend = 1'b0;
                    n_state    = S_BUCKET;
                end else if (r_rd_idx < r_used) begin
                    rd_en      = 1'b1;
                    n_cmp_pend = 1'b1;
                    n_cmp_idx  = r_rd_idx[IDX_W-1:0];
                    n_rd_idx   = r_rd_idx + CNT_W'(1);
                end else if (r_used < CNT_W'(BUCKETS)) begin
                    n_outcome  = OUT_NEW;
                    n_slot     = r_used[IDX_W-1:0];
                    n_cmp_pend = 1'b0;
                    n_state    = S_BUCKET;
                end else begin
                    n_outcome  = OUT_FULL;
                    n_slot     = '0;
                    n_cmp_pend = 1'b0;
                    n_state    = S_BUCKET;
                end
            end
            S_BUCKET: begin
                priority if (r_outcome == OUT_HIT) begin
                    wr_en   = 1'b1;
                    wr_data = {key, inc_out};
                    n_hits  = inc_out;
                end else if (r_outcome == OUT_NEW) begin
                    wr_en   = 1'b1;
                    wr_data = {key, CNT_ONE};
                    n_hits  = CNT_ONE;
                    n_used  = r_used + CNT_W'(1);
                end else begin
                    n_lost_cnt = inc_out;
                    n_hits     = '0;
                end
                n_state = S_KIND;
            end
            S_KIND: begin
                // commit only once the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_kind_cnt[r_kind] = inc_out;
                    out_load           = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        priority if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_frame_cnt <= '0;
            r_lost_cnt  <= '0;
            r_used      <= '0;
            r_cmp_pend  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < KINDS; k++) begin
                r_kind_cnt[k[KIND_W-1:0]] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_frame_cnt <= n_frame_cnt;
            r_lost_cnt  <= n_lost_cnt;
            r_used      <= n_used;
            r_cmp_pend  <= n_cmp_pend;
            r_out_valid <= n_out_valid;
            r_kind_cnt  <= n_kind_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_link    <= n_link;
        r_len     <= n_len;
        r_present <= n_present;
        r_cls_idx <= n_cls_idx;
        r_kind    <= n_kind;
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_outcome <= n_outcome;
        r_slot    <= n_slot;
        r_hits    <= n_hits;
        if (out_load) begin
            r_o_kind       <= r_kind;
            r_o_kind_total <= inc_out;
            r_o_all        <= r_frame_cnt;
            r_o_outcome    <= r_outcome;
            r_o_slot       <= slot_ext[SLOT_W-1:0];
            r_o_hits       <= r_hits;
            r_o_lost       <= r_lost_cnt;
        end
    end

    // length registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= PROFILE_LEN_RST;
            r_cfg[1] <= ENDSYS_LEN_RST;
            r_cfg[2] <= SRC_CNT_LEN_RST;
            r_cfg[3] <= DST_CNT_LEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PROFILE_LEN: r_cfg[0] <= i_cfg_data;
                REG_ENDSYS_LEN:  r_cfg[1] <= i_cfg_data;
                REG_SRC_CNT_LEN: r_cfg[2] <= i_cfg_data;
                REG_DST_CNT_LEN: r_cfg[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_o_kind;
    assign o_m_axis_tdata  = {1'b0, r_o_lost, r_o_hits, r_o_slot, r_o_outcome,
                              r_o_all, r_o_kind_total};

endmodule

`default_nettype wire
